[design/bsffa_pkg.sv]
// ----------------------------------------------------------------------------
// bsffa_pkg
// Shared types and constants for the first-fit buffer slot allocator.
// ----------------------------------------------------------------------------
package bsffa_pkg;

    // Default sizing of the slot table and of the node index space.
    localparam int unsigned MAX_SLOTS_DEF = 64;
    localparam int unsigned MAX_NODES_DEF = 4096;

    // Fixed field widths of the request and response.
    localparam int unsigned IDX_W      = 12;
    localparam int unsigned NEED_W     = 32;
    localparam int unsigned SLOT_OUT_W = 6;
    localparam int unsigned CNT_OUT_W  = 7;

    // One live range presented for allocation.
    typedef struct packed {
        logic              start_graph;
        logic [IDX_W-1:0]  birth_index;
        logic [IDX_W-1:0]  death_index;
        logic [NEED_W-1:0] need_elements;
    } t_req;

    // Allocation result for one live range.
    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  reused;
        logic [CNT_OUT_W-1:0]  slots_in_use;
        logic                  overflow;
    } t_rsp;

    // Command broadcast from the control to every slot cell.
    typedef struct packed {
        logic              exec;
        logic              append;
        logic [IDX_W-1:0]  birth;
        logic [IDX_W-1:0]  death;
        logic [NEED_W-1:0] need;
    } t_cell_cmd;

endpackage

[design/bsffa_if.sv]
// ----------------------------------------------------------------------------
// bsffa request and response channels
// Valid/ready channels that carry allocation requests and their results.
// ----------------------------------------------------------------------------
interface bsffa_req_if import bsffa_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bsffa_rsp_if import bsffa_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[design/bsffa_cell.sv]
// ----------------------------------------------------------------------------
// bsffa_cell
// One slot of the table: holds its free-after index and capacity, checks
// the current range, and takes part in the first-fit claim chain.
// ----------------------------------------------------------------------------
module bsffa_cell import bsffa_pkg::*; #(
    parameter int unsigned IDX    = 0,
    parameter int unsigned SLOT_W = 6,
    parameter int unsigned CNT_W  = 7
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [CNT_W-1:0]  i_count,
    input  logic              i_claim,
    input  logic [SLOT_W-1:0] i_pick,
    output logic              o_claim,
    output logic [SLOT_W-1:0] o_pick
);

    logic [IDX_W-1:0]  r_free_after;
    logic [NEED_W-1:0] r_capacity;

    logic in_use;
    logic hit;
    logic win;
    logic append_here;

    // The slot fits when it is allocated, already free and large enough.
    assign in_use      = i_count > CNT_W'(IDX);
    assign hit         = in_use && (r_free_after < i_cmd.birth)
                         && (r_capacity >= i_cmd.need);
    assign win         = hit && !i_claim;
    assign append_here = i_cmd.append && (i_count == CNT_W'(IDX));

    // Pass the claim and the winning index on to the next cell.
    assign o_claim = i_claim | hit;
    assign o_pick  = i_pick | (win ? SLOT_W'(IDX) : '0);

    // Update the slot when it wins or when a new slot is appended here.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (win || append_here)) begin
            r_free_after <= i_cmd.death;
            if (win) begin
                r_capacity <= (i_cmd.need > r_capacity) ? i_cmd.need : r_capacity;
            end else begin
                r_capacity <= i_cmd.need;
            end
        end
    end

endmodule

[design/buffer_slot_first_fit_allocator.sv]
// ----------------------------------------------------------------------------
// buffer_slot_first_fit_allocator
// Assigns live ranges to buffer slots, lowest free slot that is large enough
// first, appends a new slot when none fits, and reports overflow when the table is full.
//
//   Channel  | Dir | Handshake          | Payload
//   ---------+-----+--------------------+----------------------------------
//   i_req    | in  | valid / ready      | start_graph, birth, death, need
//   o_rsp    | out | valid / ready      | slot_index, reused, slots_in_use,
//            |     |                    | overflow
//
// Each request is captured into registers, then evaluated in S_EXEC: every
// slot cell compares at once and the claim chain through the cells picks the
// lowest fitting slot. A new request is taken only after the last is evaluated.
// Synchronous active-low reset empties the slot table.
// While a result waits on o_rsp, the next request is still captured; its
// evaluation holds until the output register is free.
// ----------------------------------------------------------------------------
module buffer_slot_first_fit_allocator import bsffa_pkg::*; #(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsffa_req_if.sink   i_req,
    bsffa_rsp_if.source o_rsp
);

    localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_start;
    logic [IDX_W-1:0]  r_birth;
    logic [IDX_W-1:0]  r_death;
    logic [NEED_W-1:0] r_need;
    logic              r_out_valid;
    t_rsp              r_rsp;

    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  n_count;
    logic              found;
    logic              do_append;
    logic              finish;
    logic [SLOT_W-1:0] slot_pick;
    t_cell_cmd         cell_cmd;
    logic              claim [MAX_SLOTS+1];
    logic [SLOT_W-1:0] pick  [MAX_SLOTS+1];
    logic [IDX_W-1:0]  birth_sat;
    logic [IDX_W-1:0]  death_sat;

    // Indexes beyond the node space saturate to the last node.
    assign birth_sat = (17'(i_req.payload.birth_index) >= 17'(MAX_NODES))
                       ? IDX_W'(MAX_NODES - 1) : i_req.payload.birth_index;
    assign death_sat = (17'(i_req.payload.death_index) >= 17'(MAX_NODES))
                       ? IDX_W'(MAX_NODES - 1) : i_req.payload.death_index;

    // The start flag empties the table ahead of this range.
    assign eff_count = r_start ? '0 : r_count;
    assign found     = claim[MAX_SLOTS];
    assign do_append = !found && (eff_count < CNT_W'(MAX_SLOTS));
    assign n_count   = eff_count + CNT_W'(do_append);
    assign finish    = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign slot_pick = found ? pick[MAX_SLOTS]
                     : (do_append ? eff_count[SLOT_W-1:0] : '0);

    // Command shared by all cells.
    assign cell_cmd.exec   = finish;
    assign cell_cmd.append = do_append;
    assign cell_cmd.birth  = r_birth;
    assign cell_cmd.death  = r_death;
    assign cell_cmd.need   = r_need;

    // Row of slot cells; the claim chain runs from slot 0 upward.
    assign claim[0] = 1'b0;
    assign pick[0]  = '0;

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        bsffa_cell #(
            .IDX    (g),
            .SLOT_W (SLOT_W),
            .CNT_W  (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_count (eff_count),
            .i_claim (claim[g]),
            .i_pick  (pick[g]),
            .o_claim (claim[g+1]),
            .o_pick  (pick[g+1])
        );
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

    // Sequencer, slot count and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The response register fills on completion and empties once taken.
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_start <= i_req.payload.start_graph;
                        r_birth <= birth_sat;
                        r_death <= death_sat;
                        r_need  <= i_req.payload.need_elements;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (finish) begin
                        r_count            <= n_count;
                        r_rsp.slot_index   <= SLOT_OUT_W'(slot_pick);
                        r_rsp.reused       <= found;
                        r_rsp.slots_in_use <= CNT_OUT_W'(n_count);
                        r_rsp.overflow     <= !found && !do_append;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[design/bsffa_checker.sv]
// ----------------------------------------------------------------------------
// bsffa_checker
// Port-level checks of the allocator's results, bound to the top level.
// ----------------------------------------------------------------------------
module bsffa_checker import bsffa_pkg::*; #(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);

    // An overflow reports slot zero, no reuse and a full table.
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp.overflow) |->
            (i_rsp.slot_index == '0) && !i_rsp.reused
            && (i_rsp.slots_in_use == CNT_OUT_W'(MAX_SLOTS)))
        else $error("overflow result is inconsistent");

    // A freshly appended slot is always the last one in use.
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp.overflow && !i_rsp.reused) |->
            (i_rsp.slots_in_use[SLOT_OUT_W-1:0] == i_rsp.slot_index + 1'b1))
        else $error("appended slot is not the last slot");

    // A reused slot lies inside the allocated part of the table.
    a_reuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp.reused) |->
            !i_rsp.overflow && ((MAX_SLOTS > 64)
            || (CNT_OUT_W'(i_rsp.slot_index) < i_rsp.slots_in_use)))
        else $error("reused slot is outside the table");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid && $stable(i_rsp))
        else $error("stalled result changed");

endmodule

bind buffer_slot_first_fit_allocator bsffa_checker #(
    .MAX_SLOTS (MAX_SLOTS)
) u_bsffa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for the first-fit buffer slot allocator. A driver offers live
// ranges from a queue and a monitor predicts each allocation from its own
// copy of the slot table. It then checks every result field against the
// oldest prediction, while both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
    import bsffa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_LIMIT     = MAX_SLOTS_DEF;
    localparam int IDX_MAX        = MAX_NODES_DEF - 1;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int IDLE_PCT       = 32;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT        = 500;
    localparam int DRAIN_AT       = 1000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    // One request waiting in the driver queue, with its pacing flags.
    typedef struct {
        t_req req;
        bit   drain_first;
        bit   steady;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsffa_req_if req_bus ();
    bsffa_rsp_if rsp_bus ();

    buffer_slot_first_fit_allocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_pending     pending_ranges[$];
    t_rsp         expected_results[$];
    logic [11:0]  slot_free_after_m [SLOT_LIMIT];
    logic [31:0]  slot_capacity_m   [SLOT_LIMIT];
    int           slots_used_m;
    bit           req_taken;
    bit           drain_next;
    int           results_seen;
    int           mismatch_count;
    int           idle_cycles;
    int           hold_left;
    bit           hold_done;

    always #2 i_clk = ~i_clk;

    // First-fit allocation against the testbench copy of the slot table.
    // Indices are 12 bits wide and the node space is 4096, so no index
    // ever needs to saturate.
    function automatic t_rsp allocate_range(input t_req r);
        t_rsp res;
        int   pick;
        int   s;
        res  = '0;
        pick = -1;
        if (r.start_graph)
            slots_used_m = 0;
        for (s = 0; s < slots_used_m; s++) begin
            if (pick < 0 && slot_free_after_m[s] < r.birth_index &&
                slot_capacity_m[s] >= r.need_elements)
                pick = s;
        end
        if (pick >= 0) begin
            slot_free_after_m[pick] = r.death_index;
            if (r.need_elements > slot_capacity_m[pick])
                slot_capacity_m[pick] = r.need_elements;
            res.slot_index = pick[5:0];
            res.reused     = 1'b1;
        end else if (slots_used_m < SLOT_LIMIT) begin
            slot_free_after_m[slots_used_m] = r.death_index;
            slot_capacity_m[slots_used_m]   = r.need_elements;
            res.slot_index = slots_used_m[5:0];
            slots_used_m++;
        end else begin
            res.overflow = 1'b1;
        end
        res.slots_in_use = slots_used_m[6:0];
        return res;
    endfunction

    // Queue one live range; a stretch in the middle runs without gaps.
    task automatic add_range(input bit start, input int birth, input int death,
                             input logic [31:0] need);
        t_pending p;
        p.req.start_graph   = start;
        p.req.birth_index   = birth[11:0];
        p.req.death_index   = death[11:0];
        p.req.need_elements = need;
        p.steady            = pending_ranges.size() >= 400 &&
                              pending_ranges.size() < 700;
        p.drain_first       = drain_next;
        drain_next          = 1'b0;
        pending_ranges      = {pending_ranges, p};
    endtask

    // Mostly small sizes so that capacities collide, plus the extremes.
    function automatic logic [31:0] pick_need();
        int k;
        k = $urandom_range(99);
        if (k < 5)
            return 32'd0;
        else if (k < 10)
            return 32'hFFFF_FFFF;
        else if (k < 25)
            return $urandom;
        else
            return $urandom_range(1, 16) * 256;
    endfunction

    // One graph in birth order. A long-lived graph keeps nearly every
    // range alive to the end, which fills the table and overflows it.
    task automatic emit_graph(input int len, input bit long_lived);
        int birth;
        int death;
        int life;
        int i;
        birth = long_lived ? $urandom_range(0, 100) : $urandom_range(0, 3800);
        life  = $urandom_range(1, 30);
        for (i = 0; i < len; i++) begin
            birth = birth + $urandom_range(0, 3);
            if (birth > IDX_MAX)
                birth = IDX_MAX;
            if (long_lived && $urandom_range(9) != 0)
                death = IDX_MAX - $urandom_range(0, 3);
            else
                death = birth + $urandom_range(0, life);
            if (death > IDX_MAX)
                death = IDX_MAX;
            add_range(i == 0, birth, death, pick_need());
        end
    endtask

    // Ranges with no ordering at all, death before birth included.
    task automatic emit_noise(input int len);
        int i;
        for (i = 0; i < len; i++)
            add_range($urandom_range(3) == 0, $urandom_range(0, IDX_MAX),
                      $urandom_range(0, IDX_MAX), pick_need());
    endtask

    // Request driver: offers the queue head, holds it until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (req_bus.valid && !req_taken) begin
            // The offered request has not been taken yet.
        end else if (pending_ranges.size() == 0 ||
                     (pending_ranges[0].drain_first && expected_results.size() != 0) ||
                     (!pending_ranges[0].steady && $urandom_range(99) < IDLE_PCT)) begin
            req_bus.valid <= 1'b0;
        end else begin
            req_bus.payload <= pending_ranges[0].req;
            req_bus.valid   <= 1'b1;
            void'(pending_ranges.pop_front());
        end
    end

    // Result receiver: random stalls, one long hold-off, one steady stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
        end else if (results_seen >= 1200 && results_seen < 1500) begin
            rsp_bus.ready <= 1'b1;
        end else begin
            rsp_bus.ready <= $urandom_range(99) >= IDLE_PCT;
        end
    end

    // Monitor: predicts each accepted request and checks each result.
    always @(posedge i_clk) begin
        t_rsp want;
        bit   got_result;
        req_taken  = 1'b0;
        got_result = 1'b0;
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) begin
                req_taken = 1'b1;
                expected_results = {expected_results, allocate_range(req_bus.payload)};
            end
            if (rsp_bus.valid && rsp_bus.ready) begin
                got_result = 1'b1;
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with no request pending: slot_index %0d",
                           rsp_bus.payload.slot_index);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_bus.payload.slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, rsp_bus.payload.slot_index);
                        mismatch_count++;
                    end
                    if (rsp_bus.payload.reused !== want.reused) begin
                        $error("reused: expected %0d, actual %0d",
                               want.reused, rsp_bus.payload.reused);
                        mismatch_count++;
                    end
                    if (rsp_bus.payload.slots_in_use !== want.slots_in_use) begin
                        $error("slots_in_use: expected %0d, actual %0d",
                               want.slots_in_use, rsp_bus.payload.slots_in_use);
                        mismatch_count++;
                    end
                    if (rsp_bus.payload.overflow !== want.overflow) begin
                        $error("overflow: expected %0d, actual %0d",
                               want.overflow, rsp_bus.payload.overflow);
                        mismatch_count++;
                    end
                end
            end
            // Watchdog on cycles with no accepted request or result.
            idle_cycles = (req_taken || got_result) ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int total;
        int kind;
        req_bus.valid   = 1'b0;
        req_bus.payload = '0;
        rsp_bus.ready   = 1'b0;
        i_rst_n         = 1'b0;
        slots_used_m    = 0;
        drain_next      = 1'b0;
        results_seen    = 0;
        mismatch_count  = 0;
        idle_cycles     = 0;
        hold_left       = 0;
        hold_done       = 1'b0;

        // Directed: zero and full needs, zero-need reuse, death before
        // birth, extreme indices, start flag, capacity check on reuse.
        add_range(1'b1, 0, 0, 32'd0);
        add_range(1'b0, 1, 5, 32'hFFFF_FFFF);
        add_range(1'b0, 1, 2, 32'd0);
        add_range(1'b0, 3, IDX_MAX, 32'd100);
        add_range(1'b0, IDX_MAX, IDX_MAX, 32'hFFFF_FFFF);
        add_range(1'b0, IDX_MAX, 0, 32'd0);
        add_range(1'b0, IDX_MAX, 10, 32'd50);
        add_range(1'b1, IDX_MAX, IDX_MAX, 32'd1);
        add_range(1'b1, 100, 50, 32'd7);
        add_range(1'b0, 60, 70, 32'd7);
        add_range(1'b0, 71, 80, 32'd8);
        add_range(1'b0, 81, 90, 32'd3);
        add_range(1'b0, 91, 95, 32'd8);
        // A full table right away, then overflow and a fresh graph.
        emit_graph(70, 1'b1);

        // Random: mostly ordered graphs, some table fills, some noise.
        total = pending_ranges.size() + RANDOM_ITEMS;
        while (pending_ranges.size() < total) begin
            if (pending_ranges.size() >= DRAIN_AT && pending_ranges.size() < DRAIN_AT + 80)
                drain_next = 1'b1;
            else if ($urandom_range(49) == 0)
                drain_next = 1'b1;
            kind = $urandom_range(99);
            if (kind < 70)
                emit_graph($urandom_range(4, 40), 1'b0);
            else if (kind < 85)
                emit_graph($urandom_range(60, 80), 1'b1);
            else
                emit_noise($urandom_range(1, 10));
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ranges.size() != 0 || req_bus.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
